[rtl/core/lph_pkg.sv]
// Shared types, codes and hash arithmetic for the linear probe hash table.
package lph_pkg;

  localparam int TABLE_SLOTS_DEF = 256;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int LOAD_NUM = 3;

  localparam int OP_W     = 2;
  localparam int KEYIN_W  = 64;
  localparam int LEN_W    = 4;
  localparam int VALIN_W  = 32;
  localparam int STATUS_W = 3;
  localparam int VALOUT_W = 32;
  localparam int ENTRY_W  = 9;
  localparam int HASH_W   = 64;

  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  // The prime is 2^40 + 0x1B3, so a step is a shift plus a narrow product.
  localparam logic [HASH_W-1:0] FNV_PRIME_LO = 64'h0000_0000_0000_01B3;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] RES_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] RES_REPLACED  = 3'd1;
  localparam logic [STATUS_W-1:0] RES_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] RES_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] RES_CLEARED   = 3'd5;

  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_USED = 2'd1;
  localparam logic [1:0] SLOT_TOMB = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEYIN_W-1:0] key_bytes;
    logic [LEN_W-1:0]   key_length;
    logic [VALIN_W-1:0] value_in;
  } lph_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALOUT_W-1:0] value_out;
    logic [ENTRY_W-1:0]  entry_count;
  } lph_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_req;
    logic hash_step;
    logic sweep_start_all;
    logic sweep_start_dst;
    logic sweep_step;
    logic probe_start_req;
    logic probe_start_rb;
    logic probe_read;
    logic probe_check;
    logic src_read;
    logic src_latch;
    logic src_next;
    logic rb_write;
    logic rb_finish;
    logic do_commit;
    logic out_load;
  } lph_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hash_done;
    logic is_clear;
    logic sweep_last;
    logic probe_stop;
    logic src_live;
    logic src_last;
    logic need_rebuild;
    logic out_busy;
  } lph_stat_t;

  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x * FNV_PRIME_LO);
  endfunction

endpackage

[rtl/core/lph_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/lph_ctrl.sv]
// Controller state machine that sequences hashing, clearing, probing, rebuild and results.
module lph_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lph_pkg::lph_stat_t stat,
  output lph_pkg::lph_cmd_t  cmd
);
  import lph_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_CLR    = 4'd3;
  localparam logic [3:0] S_PRD    = 4'd4;
  localparam logic [3:0] S_PCHK   = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_RCLR   = 4'd9;
  localparam logic [3:0] S_RRD    = 4'd10;
  localparam logic [3:0] S_RCHK   = 4'd11;
  localparam logic [3:0] S_RBW    = 4'd12;
  localparam logic [3:0] S_RFIN   = 4'd13;
  localparam logic [3:0] S_RPRB   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       rb_r, rb_nxt;

  always_comb begin
    state_nxt = state_r;
    rb_nxt    = rb_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_HASH;
        end
      end
      S_HASH: begin
        if (!stat.hash_done) begin
          cmd.hash_step = 1'b1;
        end else if (stat.is_clear) begin
          cmd.sweep_start_all = 1'b1;
          state_nxt           = S_CLR;
        end else begin
          cmd.probe_start_req = 1'b1;
          state_nxt           = S_PRD;
        end
      end
      S_CLR: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_PRD: begin
        cmd.probe_read = 1'b1;
        state_nxt      = S_PCHK;
      end
      S_PCHK: begin
        cmd.probe_check = 1'b1;
        if (stat.probe_stop) begin
          state_nxt = rb_r ? S_RBW : S_DECIDE;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_DECIDE: begin
        if (stat.need_rebuild) begin
          cmd.sweep_start_dst = 1'b1;
          rb_nxt              = 1'b1;
          state_nxt           = S_RCLR;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.do_commit = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RCLR: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_RRD;
        end
      end
      S_RRD: begin
        cmd.src_read = 1'b1;
        state_nxt    = S_RCHK;
      end
      S_RCHK: begin
        if (stat.src_live) begin
          cmd.src_latch      = 1'b1;
          cmd.probe_start_rb = 1'b1;
          state_nxt          = S_PRD;
        end else if (stat.src_last) begin
          state_nxt = S_RFIN;
        end else begin
          cmd.src_next = 1'b1;
          state_nxt    = S_RRD;
        end
      end
      S_RBW: begin
        cmd.rb_write = 1'b1;
        if (stat.src_last) begin
          state_nxt = S_RFIN;
        end else begin
          cmd.src_next = 1'b1;
          state_nxt    = S_RRD;
        end
      end
      S_RFIN: begin
        cmd.rb_finish = 1'b1;
        rb_nxt        = 1'b0;
        state_nxt     = S_RPRB;
      end
      S_RPRB: begin
        cmd.probe_start_req = 1'b1;
        state_nxt           = S_PRD;
      end
      default: begin
        state_nxt = S_IDLE;
        rb_nxt    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      rb_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rb_r    <= rb_nxt;
    end
  end

endmodule

[rtl/core/lph_dpath.sv]
// Datapath: request registers, hash unit, probe walker, counters, slot RAM, result word.
module lph_dpath #(
  parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = lph_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lph_pkg::lph_cmd_t  cmd,
  output lph_pkg::lph_stat_t stat,
  input  lph_pkg::lph_in_t   in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output lph_pkg::lph_out_t  out_data
);
  import lph_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int AW = SW + 1;
  localparam int CW = SW + 1;
  localparam int LW = SW + 3;
  localparam int KW = 8 * KEY_BYTES;
  localparam int VB = VALUE_BITS;
  localparam int W  = 2 + HASH_W + KW + VB;

  // Request.
  logic [OP_W-1:0]   op_r;
  logic [KW-1:0]     key_r;
  logic [LEN_W-1:0]  len_r;
  logic [VB-1:0]     val_r;
  logic [HASH_W-1:0] hash_r;
  logic [LEN_W-1:0]  hcnt_r;

  // Table state.
  logic          bank_r;
  logic [CW-1:0] live_r, tomb_r;
  logic          rebuilt_r;

  // Sweep and rebuild source walk.
  logic [AW-1:0] sweep_ctr_r;
  logic          sweep_all_r;
  logic [SW-1:0] src_r;

  // Probe walker.
  logic              probe_bank_r;
  logic [SW-1:0]     idx_r, n_r, reuse_r;
  logic              reuse_v_r;
  logic [HASH_W-1:0] ph_r;
  logic [KW-1:0]     pk_r;
  logic              found_r, slot_ok_r, slot_tomb_r;
  logic [SW-1:0]     slot_r;
  logic [VB-1:0]     old_val_r;

  // Entry being moved by a rebuild.
  logic [HASH_W-1:0] rb_hash_r;
  logic [KW-1:0]     rb_key_r;
  logic [VB-1:0]     rb_val_r;

  // Result.
  logic [STATUS_W-1:0] res_status_r;
  logic [VALOUT_W-1:0] res_value_r;
  logic                out_valid_r;
  lph_out_t            out_data_r;

  // RAM ports.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_wdata, ram_rdata;

  lph_ram #(.WIDTH(W), .DEPTH(2 * TABLE_SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [1:0]        rd_st;
  logic [HASH_W-1:0] rd_hash;
  logic [KW-1:0]     rd_key;
  logic [VB-1:0]     rd_val;

  assign rd_st   = ram_rdata[W-1 -: 2];
  assign rd_hash = ram_rdata[W-3 -: HASH_W];
  assign rd_key  = ram_rdata[KW+VB-1 -: KW];
  assign rd_val  = ram_rdata[VB-1:0];

  // Input capture: saturate the length and mask bytes past it.
  logic [LEN_W-1:0]   len_sat;
  logic [KEYIN_W-1:0] key_mask, key_masked;
  logic [63:0]        val_ext;

  always_comb begin
    len_sat = (in_data.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                       : in_data.key_length;
    for (int b = 0; b < 8; b++) begin
      key_mask[8*b +: 8] = (LEN_W'(b) < len_sat) ? 8'hFF : 8'h00;
    end
    key_masked = in_data.key_bytes & key_mask;
    val_ext    = 64'(in_data.value_in);
  end

  logic [63:0] key64;
  logic [7:0]  hbyte;
  assign key64 = 64'(key_r);
  assign hbyte = key64[{hcnt_r[2:0], 3'b000} +: 8];

  // Probe check.
  logic is_match, pc_last, reuse_take;
  assign is_match   = (rd_st == SLOT_USED) && (rd_hash == ph_r) && (rd_key == pk_r);
  assign pc_last    = (n_r == {SW{1'b1}});
  assign reuse_take = (rd_st == SLOT_TOMB) && !reuse_v_r;

  // Load bound: (live + tomb + 1) * 4 >= 3 * slots.
  logic [LW-1:0] load_sum;
  logic          load_over;
  assign load_sum  = LW'(live_r) + LW'(tomb_r) + LW'(1);
  assign load_over = {load_sum[LW-3:0], 2'b00} >= LW'(LOAD_NUM * TABLE_SLOTS);

  // Final action of a request.
  logic                c_we;
  logic [W-1:0]        c_wdata;
  logic [STATUS_W-1:0] c_status;
  logic [VB-1:0]       c_value;
  logic [CW-1:0]       c_live, c_tomb;
  logic [63:0]         c_value_ext;

  always_comb begin
    c_we     = 1'b0;
    c_wdata  = {SLOT_USED, hash_r, key_r, val_r};
    c_status = RES_NOT_FOUND;
    c_value  = '0;
    c_live   = live_r;
    c_tomb   = tomb_r;
    case (op_r)
      OP_CLEAR: begin
        c_status = RES_CLEARED;
        c_live   = '0;
        c_tomb   = '0;
      end
      OP_PUT: begin
        if (found_r) begin
          c_we     = 1'b1;
          c_status = RES_REPLACED;
          c_value  = old_val_r;
        end else if ((load_over && !rebuilt_r) || !slot_ok_r) begin
          c_status = RES_FULL;
        end else begin
          c_we     = 1'b1;
          c_status = RES_INSERTED;
          c_live   = live_r + CW'(1);
          if (slot_tomb_r && (tomb_r != '0)) begin
            c_tomb = tomb_r - CW'(1);
          end
        end
      end
      OP_GET: begin
        if (found_r) begin
          c_status = RES_FOUND;
          c_value  = old_val_r;
        end
      end
      OP_ERASE: begin
        if (found_r) begin
          c_we     = 1'b1;
          c_wdata  = {SLOT_TOMB, hash_r, key_r, {VB{1'b0}}};
          c_status = RES_FOUND;
          c_value  = old_val_r;
          c_tomb   = tomb_r + CW'(1);
          if (live_r != '0) begin
            c_live = live_r - CW'(1);
          end
        end
      end
      default: begin
        c_status = RES_NOT_FOUND;
      end
    endcase
    c_value_ext = 64'(c_value);
  end

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {bank_r, slot_r};
    ram_wdata = c_wdata;
    if (cmd.sweep_step) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_ctr_r;
      ram_wdata = {SLOT_FREE, {(W-2){1'b0}}};
    end else if (cmd.rb_write) begin
      ram_we    = slot_ok_r;
      ram_waddr = {~bank_r, slot_r};
      ram_wdata = {SLOT_USED, rb_hash_r, rb_key_r, rb_val_r};
    end else if (cmd.do_commit) begin
      ram_we = c_we;
    end
    ram_re    = cmd.probe_read || cmd.src_read;
    ram_raddr = cmd.src_read ? {bank_r, src_r} : {probe_bank_r, idx_r};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      live_r      <= '0;
      tomb_r      <= '0;
      sweep_ctr_r <= '0;
      sweep_all_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep_start_all) begin
        sweep_ctr_r <= '0;
        sweep_all_r <= 1'b1;
      end else if (cmd.sweep_start_dst) begin
        sweep_ctr_r <= {~bank_r, {SW{1'b0}}};
        sweep_all_r <= 1'b0;
      end else if (cmd.sweep_step) begin
        sweep_ctr_r <= sweep_ctr_r + AW'(1);
      end
      if (cmd.rb_finish) begin
        bank_r <= ~bank_r;
        tomb_r <= '0;
      end else if (cmd.do_commit) begin
        live_r <= c_live;
        tomb_r <= c_tomb;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      op_r      <= in_data.operation;
      key_r     <= key_masked[KW-1:0];
      len_r     <= len_sat;
      val_r     <= val_ext[VB-1:0];
      hash_r    <= FNV_BASIS;
      hcnt_r    <= '0;
      rebuilt_r <= 1'b0;
    end else if (cmd.hash_step) begin
      hash_r <= fnv_step(hash_r, hbyte);
      hcnt_r <= hcnt_r + LEN_W'(1);
    end
    if (cmd.rb_finish) begin
      rebuilt_r <= 1'b1;
    end

    if (cmd.sweep_start_dst) begin
      src_r <= '0;
    end else if (cmd.src_next) begin
      src_r <= src_r + SW'(1);
    end

    if (cmd.src_latch) begin
      rb_hash_r <= rd_hash;
      rb_key_r  <= rd_key;
      rb_val_r  <= rd_val;
    end

    if (cmd.probe_start_req) begin
      ph_r         <= hash_r;
      pk_r         <= key_r;
      probe_bank_r <= bank_r;
      idx_r        <= hash_r[SW-1:0];
      n_r          <= '0;
      reuse_v_r    <= 1'b0;
    end else if (cmd.probe_start_rb) begin
      ph_r         <= rd_hash;
      pk_r         <= rd_key;
      probe_bank_r <= ~bank_r;
      idx_r        <= rd_hash[SW-1:0];
      n_r          <= '0;
      reuse_v_r    <= 1'b0;
    end else if (cmd.probe_check) begin
      if (rd_st == SLOT_FREE) begin
        found_r     <= 1'b0;
        slot_r      <= reuse_v_r ? reuse_r : idx_r;
        slot_ok_r   <= 1'b1;
        slot_tomb_r <= reuse_v_r;
      end else if (is_match) begin
        found_r     <= 1'b1;
        slot_r      <= idx_r;
        slot_ok_r   <= 1'b1;
        slot_tomb_r <= 1'b0;
        old_val_r   <= rd_val;
      end else begin
        if (reuse_take) begin
          reuse_r   <= idx_r;
          reuse_v_r <= 1'b1;
        end
        if (pc_last) begin
          found_r     <= 1'b0;
          slot_r      <= reuse_take ? idx_r : reuse_r;
          slot_ok_r   <= reuse_v_r || reuse_take;
          slot_tomb_r <= 1'b1;
        end else begin
          idx_r <= idx_r + SW'(1);
          n_r   <= n_r + SW'(1);
        end
      end
    end

    if (cmd.do_commit) begin
      res_status_r <= c_status;
      res_value_r  <= c_value_ext[VALOUT_W-1:0];
    end
    if (cmd.out_load) begin
      out_data_r.status      <= res_status_r;
      out_data_r.value_out   <= res_value_r;
      out_data_r.entry_count <= ENTRY_W'(live_r);
    end
  end

  always_comb begin
    stat.hash_done    = (hcnt_r == len_r);
    stat.is_clear     = (op_r == OP_CLEAR);
    stat.sweep_last   = sweep_all_r ? (sweep_ctr_r == {AW{1'b1}})
                                    : (sweep_ctr_r[SW-1:0] == {SW{1'b1}});
    stat.probe_stop   = (rd_st == SLOT_FREE) || is_match || pc_last;
    stat.src_live     = (rd_st == SLOT_USED);
    stat.src_last     = (src_r == {SW{1'b1}});
    stat.need_rebuild = (op_r == OP_PUT) && !found_r && load_over &&
                        (tomb_r != '0) && !rebuilt_r;
    stat.out_busy     = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/linear_probe_hash_table_unit.sv]
// Top level of the linear probe hash table: controller plus datapath.
//
//   Port group   Direction   Handshake            Word
//   in_*         input       in_valid/in_ready    lph_in_t  (operation, key, length, value)
//   out_*        output      out_valid/out_ready  lph_out_t (status, value, entry count)
//
// A request is accepted, its key is hashed one byte at a time up to the key
// length, each probed slot is read from the RAM and then checked, and the
// controller then decides, commits and posts the result.
// A clear sweeps both banks of the slot RAM. A put that trips the load bound
// while tombstones remain rebuilds first: it empties the other bank, reads each
// source slot, and for each moved entry probes the other bank and writes it;
// then it switches banks and probes again. With no tombstones it is full.
// After reset the block runs the same clearing pass over both banks before
// in_ready rises. A waiting result sits in the output register and does not
// block acceptance of the next word; only a second finished result waits.
module linear_probe_hash_table_unit #(
  parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = lph_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lph_pkg::lph_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lph_pkg::lph_out_t out_data
);
  import lph_pkg::*;

  // The controller only sequences; every table and request register lives
  // in the datapath.
  lph_cmd_t  cmd;
  lph_stat_t stat;

  lph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lph_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/linear_probe_hash_table_unit_tb.sv]
// Testbench for the linear probe hash table: directed and random requests checked by a predictor.
module linear_probe_hash_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lph_pkg::*;

  localparam int SLOTS = 256;
  localparam int KEYB = 8;
  localparam longint unsigned PRIME = 64'd1099511628211;
  localparam int LIMIT = 20000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  lph_in_t in_data;
  logic out_valid;
  logic out_ready;
  lph_out_t out_data;

  linear_probe_hash_table_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: two banks of slots, as in the block.
  logic [1:0] tbl_state [2*SLOTS];
  logic [63:0] tbl_hash [2*SLOTS];
  logic [63:0] tbl_key [2*SLOTS];
  logic [31:0] tbl_val [2*SLOTS];
  int unsigned live_n;
  int unsigned tomb_n;
  int unsigned bank;

  lph_out_t pending_results[$];
  int errors;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  // A small pool of keys keeps random requests hitting existing entries.
  logic [63:0] key_pool [16];
  logic [3:0] len_pool [16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[linear_probe_hash_table_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] fnv_hash(input logic [63:0] k, input int unsigned len);
    logic [63:0] h;
    h = 64'hCBF2_9CE4_8422_2325;
    for (int i = 0; i < len; i++) begin
      h = h ^ {56'd0, k[8*i +: 8]};
      h = h * PRIME;
    end
    return h;
  endfunction

  // Walk one bank from the home slot; returns match, else first tombstone,
  // else first empty slot, else SLOTS.
  function automatic int unsigned walk_bank(input int unsigned b, input logic [63:0] h,
                                            input logic [63:0] k, output bit hit);
    int unsigned idx;
    int unsigned reuse;
    int unsigned at;
    idx = 32'(h % SLOTS);
    reuse = SLOTS;
    hit = 0;
    for (int n = 0; n < SLOTS; n++) begin
      at = b * SLOTS + idx;
      if (tbl_state[at] == SLOT_FREE) return (reuse != SLOTS) ? reuse : idx;
      if (tbl_state[at] == SLOT_TOMB) begin
        if (reuse == SLOTS) reuse = idx;
      end else if (tbl_hash[at] == h && tbl_key[at] == k) begin
        hit = 1;
        return idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    return reuse;
  endfunction

  function automatic void compact_into_other_bank();
    int unsigned src;
    int unsigned nb;
    int unsigned d;
    bit hit;
    src = bank * SLOTS;
    nb = bank ^ 1;
    for (int i = 0; i < SLOTS; i++) tbl_state[nb*SLOTS + i] = SLOT_FREE;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_state[src + i] == SLOT_USED) begin
        d = walk_bank(nb, tbl_hash[src + i], tbl_key[src + i], hit);
        if (d < SLOTS) begin
          tbl_state[nb*SLOTS + d] = SLOT_USED;
          tbl_hash[nb*SLOTS + d] = tbl_hash[src + i];
          tbl_key[nb*SLOTS + d] = tbl_key[src + i];
          tbl_val[nb*SLOTS + d] = tbl_val[src + i];
        end
      end
    end
    bank = nb;
    tomb_n = 0;
  endfunction

  function automatic lph_out_t table_response(input lph_in_t req);
    lph_out_t r;
    int unsigned len;
    int unsigned s;
    int unsigned at;
    logic [63:0] k;
    logic [63:0] h;
    bit hit;
    r.status = RES_NOT_FOUND;
    r.value_out = '0;
    len = (req.key_length > KEYB) ? KEYB : req.key_length;
    k = req.key_bytes;
    if (len < 8) k = k & ((64'd1 << (8*len)) - 64'd1);
    h = fnv_hash(k, len);
    if (req.operation == OP_CLEAR) begin
      for (int i = 0; i < 2*SLOTS; i++) tbl_state[i] = SLOT_FREE;
      live_n = 0;
      tomb_n = 0;
      r.status = RES_CLEARED;
    end else begin
      s = walk_bank(bank, h, k, hit);
      if (req.operation == OP_PUT) begin
        if (hit) begin
          at = bank*SLOTS + s;
          r.value_out = tbl_val[at];
          tbl_val[at] = req.value_in;
          r.status = RES_REPLACED;
        end else begin
          bit ok;
          ok = 1;
          if ((live_n + tomb_n + 1) * 4 >= SLOTS * LOAD_NUM) begin
            if (tomb_n == 0) ok = 0;
            else begin
              compact_into_other_bank();
              s = walk_bank(bank, h, k, hit);
            end
          end
          if (ok && s < SLOTS) begin
            at = bank*SLOTS + s;
            if (tbl_state[at] == SLOT_TOMB && tomb_n > 0) tomb_n--;
            tbl_state[at] = SLOT_USED;
            tbl_hash[at] = h;
            tbl_key[at] = k;
            tbl_val[at] = req.value_in;
            live_n++;
            r.status = RES_INSERTED;
          end else begin
            r.status = RES_FULL;
          end
        end
      end else if (hit) begin
        at = bank*SLOTS + s;
        r.value_out = tbl_val[at];
        r.status = RES_FOUND;
        if (req.operation == OP_ERASE) begin
          tbl_state[at] = SLOT_TOMB;
          tbl_val[at] = '0;
          if (live_n > 0) live_n--;
          tomb_n++;
        end
      end
    end
    r.entry_count = live_n[ENTRY_W-1:0];
    return r;
  endfunction

  // Sends one word; the expected result is queued at the accepting edge.
  // Valid is dropped only when the sender idles, so back-to-back calls never
  // drive it twice in one time step.
  task automatic send_word(input lph_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(table_response(req));
    @(negedge clk);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [63:0] k, input logic [3:0] len,
                         input logic [31:0] v);
    lph_in_t req;
    req.operation = op;
    req.key_bytes = k;
    req.key_length = len;
    req.value_in = v;
    send_word(req);
  endtask

  // Receiver side: random stalls, compare each word with the oldest expectation.
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    lph_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.status !== out_data.status || want.value_out !== out_data.value_out ||
            want.entry_count !== out_data.entry_count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected st=%0d val=%h cnt=%0d, got st=%0d val=%h cnt=%0d",
                     want.status, want.value_out, want.entry_count,
                     out_data.status, out_data.value_out, out_data.entry_count);
        end
      end
    end
  end

  function automatic logic [63:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Extremes of every field, each operation and the special key cases.
  task automatic test_directed();
    send_op(OP_GET, 64'h0, 4'd0, 32'h0);
    send_op(OP_PUT, 64'h0, 4'd0, 32'hFFFF_FFFF);
    send_op(OP_PUT, 64'h0, 4'd0, 32'h1234_5678);
    send_op(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h0);
    // Length above eight saturates, so these three name the same key.
    send_op(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hA5A5_A5A5);
    send_op(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
    send_op(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h0);
    // A zero byte inside the length is part of the key.
    send_op(OP_PUT, 64'h0000_0041, 4'd2, 32'h1);
    send_op(OP_GET, 64'h0000_0041, 4'd1, 32'h0);
    send_op(OP_GET, 64'hFF00_0041, 4'd2, 32'h0);
    send_op(OP_ERASE, 64'h0000_0041, 4'd2, 32'h0);
    send_op(OP_ERASE, 64'h0000_0041, 4'd2, 32'h0);
    send_op(OP_GET, 64'h0000_0041, 4'd2, 32'h0);
    send_op(OP_PUT, 64'h0000_0041, 4'd2, 32'h2);
    send_op(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
    send_op(OP_GET, 64'h0, 4'd0, 32'h0);
    send_op(OP_ERASE, 64'h5555_AAAA_5555_AAAA, 4'd7, 32'h0);
  endtask

  // Fill to the load bound with no tombstones so puts are refused as full,
  // then erase some and put again so the table is rebuilt into the other bank.
  task automatic test_full_and_rebuild();
    for (int i = 0; i < 195; i++) send_op(OP_PUT, 64'h1_0000 + i, 4'd3, $urandom);
    send_op(OP_PUT, 64'hBEEF, 4'd4, 32'h77);
    for (int i = 0; i < 20; i++) send_op(OP_ERASE, 64'h1_0000 + 3*i, 4'd3, 32'h0);
    for (int i = 0; i < 25; i++) send_op(OP_PUT, 64'h2_0000 + i, 4'd3, $urandom);
    for (int i = 0; i < 20; i++) send_op(OP_GET, 64'h1_0000 + $urandom_range(194), 4'd3, 0);
    send_op(OP_CLEAR, 64'h0, 4'd0, 32'h0);
  endtask

  task automatic test_random(input int count);
    lph_in_t req;
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(15);
      if ($urandom_range(9) < 8) begin
        req.key_bytes = key_pool[p];
        req.key_length = len_pool[p];
      end else begin
        req.key_bytes = random_key();
        req.key_length = LEN_W'($urandom_range(15));
      end
      req.operation = ($urandom_range(99) < 2) ? OP_CLEAR : OP_W'($urandom_range(2));
      req.value_in = $urandom;
      send_word(req);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    live_n = 0;
    tomb_n = 0;
    bank = 0;
    for (int i = 0; i < 2*SLOTS; i++) begin
      tbl_state[i] = SLOT_FREE;
      tbl_hash[i] = '0;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = random_key();
      len_pool[i] = LEN_W'($urandom_range(15));
    end
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_and_rebuild();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(120);
    send_idle_pct = 60; recv_stall_pct = 0;  test_random(120);
    send_idle_pct = 0;  recv_stall_pct = 60; test_random(120);
    send_idle_pct = 21; recv_stall_pct = 21; test_random(120);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(60);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[linear_probe_hash_table_unit] OK");
    end else begin
      $display("[linear_probe_hash_table_unit] ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/lph_pkg.sv
rtl/core/lph_ram.sv
rtl/core/lph_ctrl.sv
rtl/core/lph_dpath.sv
rtl/core/linear_probe_hash_table_unit.sv
tb/linear_probe_hash_table_unit_tb.sv
